// File: design/multilevel_feedback_scheduler_macros.svh
// Assertion macros for the multilevel feedback scheduler.
// Included by the top level; no other dependencies.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
`define MLFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlfs: same-cycle property violated");
`define MLFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlfs: next-cycle property violated");
`else
`define MLFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MLFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/mlfs_pkg.sv
// Shared types and constants of the multilevel feedback scheduler.
// No dependencies; used by the controller, the datapath and the top level.
package mlfs_pkg;

  localparam int ID_W        = 8;
  localparam int BURST_W     = 16;
  localparam int QUANT_W     = 8;
  localparam int EVENT_W     = 3;
  localparam int LEVEL_OUT_W = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int QUANT_COUNT = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2 = 2'd2;

  localparam logic [QUANT_W-1:0] QUANT_RESET [QUANT_COUNT] = '{8'd1, 8'd2, 8'd6};
  localparam logic [QUANT_W-1:0] QUANT_MAX = 8'd255;

  localparam logic [EVENT_W-1:0] EV_RAN_ON   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_FINISHED = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DEMOTED  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_IDLE     = 3'd3;
  localparam logic [EVENT_W-1:0] EV_QUEUED   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_DROPPED  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_PICK,
    ST_RUN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic arrive;
    logic pick;
    logic run;
  } cmd_t;

  typedef struct packed {
    logic run_valid;
    logic any_ready;
  } status_t;

endpackage

// File: design/mlfs_datapath.sv
// Datapath of the multilevel feedback scheduler: queue memory, ring pointers,
// running process, quantum registers and result register. Uses mlfs_pkg.
module mlfs_datapath import mlfs_pkg::*; #(
  parameter int LEVEL_COUNT = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic [ID_W-1:0]        proc_id_i,
  input  logic [BURST_W-1:0]     burst_time_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [QUANT_W-1:0]     cfg_data_i,
  output logic                   done_o,
  output logic                   ran_valid_o,
  output logic [ID_W-1:0]        ran_id_o,
  output logic [LEVEL_OUT_W-1:0] ran_level_o,
  output logic                   still_running_o,
  output logic [EVENT_W-1:0]     event_res_o
);

  localparam int LVL_W     = $clog2(LEVEL_COUNT);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int TW        = (TIME_BITS < BURST_W) ? TIME_BITS : BURST_W;
  localparam int ENT_W     = ID_W + TW;
  localparam int ADDR_W    = LVL_W + PTR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVEL_COUNT - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ring_pos(logic [PTR_W-1:0] head,
                                                logic [CNT_W-1:0] off);
    logic [PTR_W+1:0] sum;
    sum = (PTR_W+2)'(head) + (PTR_W+2)'(off);
    if (sum >= (PTR_W+2)'(QUEUE_DEPTH)) sum = sum - (PTR_W+2)'(QUEUE_DEPTH);
    return sum[PTR_W-1:0];
  endfunction

  logic [ENT_W-1:0]   mem_q [MEM_DEPTH];
  logic [ENT_W-1:0]   rdata_q;
  logic [PTR_W-1:0]   heads_q  [LEVEL_COUNT];
  logic [CNT_W-1:0]   counts_q [LEVEL_COUNT];
  logic [QUANT_W-1:0] quanta_q [QUANT_COUNT];

  logic               run_valid_q;
  logic [LVL_W-1:0]   run_level_q;
  logic [QUANT_W-1:0] quantum_q;
  logic               from_mem_q;
  logic [ID_W-1:0]    run_id_q;
  logic [TW-1:0]      run_time_q;
  logic [ID_W-1:0]    in_id_q;
  logic [TW-1:0]      in_time_q;

  logic                   done_q;
  logic                   ran_valid_q;
  logic [ID_W-1:0]        ran_id_q;
  logic [LEVEL_OUT_W-1:0] ran_level_q;
  logic                   still_q;
  logic [EVENT_W-1:0]     event_q;

  logic               any_ready;
  logic [LVL_W-1:0]   pick_lvl;
  logic [LVL_W-1:0]   sel_lvl;
  logic [PTR_W-1:0]   sel_head;
  logic [CNT_W-1:0]   sel_count;
  logic [PTR_W-1:0]   pop_pos;
  logic [PTR_W-1:0]   sel_tail;
  logic [PTR_W-1:0]   arr_tail;
  logic               arr_ok;
  logic [ID_W-1:0]    cur_id;
  logic [TW-1:0]      cur_time;
  logic [TW-1:0]      time_dec;
  logic [QUANT_W-1:0] q_inc;
  logic [QUANT_W-1:0] qlim;
  logic               has_quantum;
  logic               finish;
  logic               demote_hit;
  logic               room;
  logic               demote_ok;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]   mem_wdata;

  always_comb begin
    any_ready = 1'b0;
    pick_lvl  = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (!any_ready && counts_q[i] != '0) begin
        any_ready = 1'b1;
        pick_lvl  = LVL_W'(i);
      end
    end
  end

  assign has_quantum = (run_level_q != LAST_LVL);
  assign sel_lvl     = (cmd_i.run && has_quantum) ? run_level_q + LVL_W'(1) : pick_lvl;
  assign sel_head    = heads_q[sel_lvl];
  assign sel_count   = counts_q[sel_lvl];
  assign pop_pos     = (pick_lvl != LAST_LVL) ? sel_head
                                              : ring_pos(sel_head, sel_count - CNT_W'(1));
  assign sel_tail    = ring_pos(sel_head, sel_count);
  assign arr_tail    = ring_pos(heads_q[0], counts_q[0]);
  assign arr_ok      = (in_time_q != '0) && (counts_q[0] != DEPTH_C);

  assign cur_id   = from_mem_q ? rdata_q[ENT_W-1:TW] : run_id_q;
  assign cur_time = from_mem_q ? rdata_q[TW-1:0] : run_time_q;
  assign time_dec = (cur_time != '0) ? cur_time - TW'(1) : cur_time;
  assign q_inc    = (quantum_q != QUANT_MAX) ? quantum_q + QUANT_W'(1) : quantum_q;

  always_comb begin
    qlim = '0;
    for (int i = 0; i < QUANT_COUNT; i++) begin
      if (32'(run_level_q) == i) qlim = quanta_q[i];
    end
  end

  assign finish     = (time_dec == '0);
  assign demote_hit = !finish && has_quantum && (q_inc == qlim);
  assign room       = (sel_count != DEPTH_C);
  assign demote_ok  = demote_hit && room;

  assign mem_we    = (cmd_i.arrive && arr_ok) || (cmd_i.run && demote_ok);
  assign mem_waddr = cmd_i.arrive ? {LVL_W'(0), arr_tail} : {sel_lvl, sel_tail};
  assign mem_wdata = cmd_i.arrive ? {in_id_q, in_time_q} : {cur_id, time_dec};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.pick) begin
      rdata_q <= mem_q[{pick_lvl, pop_pos}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        heads_q[i]  <= '0;
        counts_q[i] <= '0;
      end
    end else if (cmd_i.arrive && arr_ok) begin
      counts_q[0] <= counts_q[0] + CNT_W'(1);
    end else if (cmd_i.pick && any_ready) begin
      counts_q[pick_lvl] <= sel_count - CNT_W'(1);
      if (pick_lvl != LAST_LVL) begin
        heads_q[pick_lvl] <= ring_pos(sel_head, CNT_W'(1));
      end
    end else if (cmd_i.run && demote_ok) begin
      counts_q[sel_lvl] <= sel_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUANT_COUNT; i++) begin
        quanta_q[i] <= QUANT_RESET[i];
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_QUANTUM0: quanta_q[0] <= cfg_data_i;
        CFG_QUANTUM1: quanta_q[1] <= cfg_data_i;
        CFG_QUANTUM2: quanta_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_level_q <= '0;
      quantum_q   <= '0;
      from_mem_q  <= 1'b0;
    end else if (cmd_i.pick && any_ready) begin
      run_valid_q <= 1'b1;
      run_level_q <= pick_lvl;
      quantum_q   <= '0;
      from_mem_q  <= 1'b1;
    end else if (cmd_i.run) begin
      from_mem_q <= 1'b0;
      if (finish) begin
        run_valid_q <= 1'b0;
        quantum_q   <= '0;
      end else if (demote_hit) begin
        quantum_q <= '0;
        if (room) run_valid_q <= 1'b0;
      end else begin
        quantum_q <= q_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_id_q   <= proc_id_i;
      in_time_q <= burst_time_i[TW-1:0];
    end
    if (cmd_i.run) begin
      run_id_q   <= cur_id;
      run_time_q <= time_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.arrive || cmd_i.run || (cmd_i.pick && !any_ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run) begin
      ran_valid_q <= 1'b1;
      ran_id_q    <= cur_id;
      ran_level_q <= LEVEL_OUT_W'(run_level_q);
      still_q     <= !finish && !demote_ok;
      event_q     <= finish ? EV_FINISHED : (demote_ok ? EV_DEMOTED : EV_RAN_ON);
    end else if (cmd_i.arrive || cmd_i.pick) begin
      ran_valid_q <= 1'b0;
      ran_id_q    <= '0;
      ran_level_q <= '0;
      still_q     <= 1'b0;
      event_q     <= cmd_i.arrive ? (arr_ok ? EV_QUEUED : EV_DROPPED) : EV_IDLE;
    end
  end

  assign status_o.run_valid = run_valid_q;
  assign status_o.any_ready = any_ready;

  assign done_o          = done_q;
  assign ran_valid_o     = ran_valid_q;
  assign ran_id_o        = ran_id_q;
  assign ran_level_o     = ran_level_q;
  assign still_running_o = still_q;
  assign event_res_o     = event_q;

endmodule

// File: design/mlfs_ctrl.sv
// Controller state machine of the multilevel feedback scheduler.
// Issues commands to mlfs_datapath; uses mlfs_pkg.
module mlfs_ctrl import mlfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    kind_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (kind_i) state_d = ST_ARRIVE;
          else if (status_i.run_valid) state_d = ST_RUN;
          else state_d = ST_PICK;
        end
      end
      ST_PICK:   state_d = status_i.any_ready ? ST_RUN : ST_IDLE;
      ST_ARRIVE: state_d = ST_IDLE;
      ST_RUN:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load   = (state_q == ST_IDLE) && start_i;
    cmd_o.arrive = (state_q == ST_ARRIVE);
    cmd_o.pick   = (state_q == ST_PICK);
    cmd_o.run    = (state_q == ST_RUN);
    busy_o       = (state_q != ST_IDLE);
  end

endmodule

// File: design/multilevel_feedback_scheduler.sv
// Top level of the multilevel feedback scheduler.
// Instantiates mlfs_ctrl and mlfs_datapath; uses mlfs_pkg and the macro header.
// An arrival (kind_i = 1) or a tick (kind_i = 0) is taken when start_i is high and busy_o is
// low; every request gives exactly one result, shown for one cycle with done_o, which the
// receiver must take as it comes. An arrival passes the arrive state. A tick goes to the
// run state when a process already holds the processor, to the pick state alone when all
// queues are empty, and else to pick, with a registered read of the queue memory, then run.
// Quantum registers are written through cfg_valid_i/cfg_index_i/cfg_data_i, always ready.
`include "multilevel_feedback_scheduler_macros.svh"

module multilevel_feedback_scheduler import mlfs_pkg::*; #(
  parameter int LEVEL_COUNT = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   kind_i,
  input  logic [ID_W-1:0]        proc_id_i,
  input  logic [BURST_W-1:0]     burst_time_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [QUANT_W-1:0]     cfg_data_i,
  output logic                   done_o,
  output logic                   ran_valid_o,
  output logic [ID_W-1:0]        ran_id_o,
  output logic [LEVEL_OUT_W-1:0] ran_level_o,
  output logic                   still_running_o,
  output logic [EVENT_W-1:0]     event_res_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  mlfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  mlfs_datapath #(
    .LEVEL_COUNT (LEVEL_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .proc_id_i       (proc_id_i),
    .burst_time_i    (burst_time_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .ran_valid_o     (ran_valid_o),
    .ran_id_o        (ran_id_o),
    .ran_level_o     (ran_level_o),
    .still_running_o (still_running_o),
    .event_res_o     (event_res_o)
  );

  `MLFS_ASSERT_IMPL(a_done_after_work, clk_i, rst_ni, done_o, $past(busy_o))
  `MLFS_ASSERT_IMPL(a_done_when_free, clk_i, rst_ni, done_o, !busy_o)
  `MLFS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `MLFS_ASSERT_IMPL(a_still_holds, clk_i, rst_ni, done_o && still_running_o, status.run_valid)

endmodule

// File: bench/tb_multilevel_feedback_scheduler.sv
// Self-checking testbench for multilevel_feedback_scheduler: directed and random requests,
// each result predicted by a cycle-free model of the four queue levels and compared in order.
// Depends on mlfs_pkg and the design top level only.
`timescale 1ns / 1ps

module tb_multilevel_feedback_scheduler import mlfs_pkg::*;;

  localparam int LEVELS        = 4;
  localparam int LAST_LEVEL    = LEVELS - 1;
  localparam int DEPTH         = 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT  = 10;
  localparam int DRAIN_LIMIT   = 2000;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_ARRIVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic                   ran_valid;
    logic [ID_W-1:0]        ran_id;
    logic [LEVEL_OUT_W-1:0] ran_level;
    logic                   still_running;
    logic [EVENT_W-1:0]     event_res;
  } sched_result_t;

  logic                   clk_i;
  logic                   rst_ni       = 1'b0;
  logic                   start_i      = 1'b0;
  logic                   kind_i       = 1'b0;
  logic [ID_W-1:0]        proc_id_i    = '0;
  logic [BURST_W-1:0]     burst_time_i = '0;
  logic                   cfg_valid_i  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i  = '0;
  logic [QUANT_W-1:0]     cfg_data_i   = '0;
  logic                   busy_o;
  logic                   cfg_ready_o;
  logic                   done_o;
  logic                   ran_valid_o;
  logic [ID_W-1:0]        ran_id_o;
  logic [LEVEL_OUT_W-1:0] ran_level_o;
  logic                   still_running_o;
  logic [EVENT_W-1:0]     event_res_o;

  multilevel_feedback_scheduler u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .proc_id_i       (proc_id_i),
    .burst_time_i    (burst_time_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .ran_valid_o     (ran_valid_o),
    .ran_id_o        (ran_id_o),
    .ran_level_o     (ran_level_o),
    .still_running_o (still_running_o),
    .event_res_o     (event_res_o)
  );

  // scheduler model state
  logic [ID_W-1:0]    lvl_id   [LEVELS][DEPTH];
  logic [BURST_W-1:0] lvl_time [LEVELS][DEPTH];
  logic [3:0]         lvl_head [LEVELS];
  logic [4:0]         lvl_count[LEVELS];
  logic               cpu_busy;
  logic [ID_W-1:0]    cpu_id;
  logic [BURST_W-1:0] cpu_time;
  logic [1:0]         cpu_level;
  logic [QUANT_W-1:0] slice_count;
  logic [QUANT_W-1:0] quantum [QUANT_COUNT];

  sched_result_t pending_results[$];

  bit gaps_on;
  int error_count;
  int unexpected_count;
  int results_seen;
  int arrivals_sent;
  int ticks_sent;
  int quantum_writes;
  int event_hits [int'(EV_DROPPED) + 1];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_multilevel_feedback_scheduler failed");
    $finish;
  end

  function automatic bit push_level(input int lvl, input logic [ID_W-1:0] id,
                                    input logic [BURST_W-1:0] t);
    logic [3:0] pos;
    if (lvl_count[lvl] >= DEPTH) return 1'b0;
    pos = lvl_head[lvl] + lvl_count[lvl][3:0];
    lvl_id[lvl][pos]   = id;
    lvl_time[lvl][pos] = t;
    lvl_count[lvl]     = lvl_count[lvl] + 5'd1;
    return 1'b1;
  endfunction

  function automatic sched_result_t advance_scheduler(input logic k,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [BURST_W-1:0] bt);
    sched_result_t r;
    logic [3:0]    pos;
    int            lvl;
    r = '0;
    if (k == KIND_ARRIVAL) begin
      if (bt != '0 && push_level(0, id, bt)) r.event_res = EV_QUEUED;
      else r.event_res = EV_DROPPED;
      return r;
    end
    if (!cpu_busy) begin
      for (lvl = 0; lvl < LEVELS; lvl++) begin
        if (lvl_count[lvl] != '0) begin
          if (lvl < LAST_LEVEL) begin
            pos = lvl_head[lvl];
            lvl_head[lvl] = lvl_head[lvl] + 4'd1;
          end else begin
            pos = lvl_head[lvl] + lvl_count[lvl][3:0] - 4'd1;
          end
          cpu_id         = lvl_id[lvl][pos];
          cpu_time       = lvl_time[lvl][pos];
          lvl_count[lvl] = lvl_count[lvl] - 5'd1;
          cpu_level      = 2'(lvl);
          slice_count    = '0;
          cpu_busy       = 1'b1;
          break;
        end
      end
    end
    if (!cpu_busy) begin
      r.event_res = EV_IDLE;
      return r;
    end
    r.ran_valid = 1'b1;
    r.ran_id    = cpu_id;
    r.ran_level = cpu_level;
    if (cpu_time != '0) cpu_time = cpu_time - 1'b1;
    if (slice_count < QUANT_MAX) slice_count = slice_count + 1'b1;
    if (cpu_time == '0) begin
      cpu_busy    = 1'b0;
      slice_count = '0;
      r.event_res = EV_FINISHED;
    end else if (int'(cpu_level) < LAST_LEVEL && slice_count == quantum[cpu_level]) begin
      // demotion into a full level keeps the process running
      slice_count = '0;
      if (push_level(int'(cpu_level) + 1, cpu_id, cpu_time)) begin
        cpu_busy    = 1'b0;
        r.event_res = EV_DEMOTED;
      end else begin
        r.still_running = 1'b1;
        r.event_res     = EV_RAN_ON;
      end
    end else begin
      r.still_running = 1'b1;
      r.event_res     = EV_RAN_ON;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    sched_result_t got;
    sched_result_t want;
    if (rst_ni && done_o) begin
      got = {ran_valid_o, ran_id_o, ran_level_o, still_running_o, event_res_o};
      if (pending_results.size() == 0) begin
        unexpected_count++;
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result: id=%0d level=%0d event=%0d", got.ran_id,
                   got.ran_level, got.event_res);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (want.event_res <= EV_DROPPED) event_hits[want.event_res]++;
        if (got !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"mismatch: expected valid=%0d id=%0d level=%0d still=%0d event=%0d,",
                      " got valid=%0d id=%0d level=%0d still=%0d event=%0d"},
                     want.ran_valid, want.ran_id, want.ran_level, want.still_running,
                     want.event_res, got.ran_valid, got.ran_id, got.ran_level,
                     got.still_running, got.event_res);
        end
      end
    end
  end

  task automatic send_request(input logic k, input logic [ID_W-1:0] id,
                              input logic [BURST_W-1:0] bt);
    int gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    kind_i       <= k;
    proc_id_i    <= id;
    burst_time_i <= bt;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(advance_scheduler(k, id, bt));
    if (k == KIND_ARRIVAL) arrivals_sent++;
    else ticks_sent++;
  endtask

  task automatic send_tick();
    send_request(KIND_TICK, ID_W'($urandom), BURST_W'($urandom));
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [CFG_IDX_W-1:0] idx, input logic [QUANT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < QUANT_COUNT) quantum[idx] = val;
    quantum_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_quanta(input logic [QUANT_W-1:0] q0, input logic [QUANT_W-1:0] q1,
                            input logic [QUANT_W-1:0] q2);
    wait_for_results();
    write_quantum(CFG_QUANTUM0, q0);
    write_quantum(CFG_QUANTUM1, q1);
    write_quantum(CFG_QUANTUM2, q2);
  endtask

  // tick until the model holds no work, then one idle tick
  task automatic drain_ticks();
    while (cpu_busy || (lvl_count[0] | lvl_count[1] | lvl_count[2] | lvl_count[3]) != '0)
      send_tick();
    send_tick();
  endtask

  // reset quanta, empty queues, drops, id extremes, demotion and finish
  task automatic test_basic_flow();
    gaps_on = 1'b1;
    send_tick();
    send_request(KIND_ARRIVAL, 8'h00, 16'd0);
    send_request(KIND_ARRIVAL, 8'hFF, 16'd1);
    send_tick();
    send_request(KIND_ARRIVAL, 8'h01, 16'd3);
    send_request(KIND_ARRIVAL, 8'h02, 16'd2);
    drain_ticks();
  endtask

  task automatic test_quantum_zero();
    wait_for_results();
    write_quantum(CFG_QUANTUM0, 8'd0);
    write_quantum(CFG_UNUSED_IDX, 8'hA5);
    send_request(KIND_ARRIVAL, 8'h5A, 16'd5);
    drain_ticks();
  endtask

  task automatic test_last_level_order();
    set_quanta(8'd1, 8'd1, 8'd1);
    send_request(KIND_ARRIVAL, 8'h11, 16'd4);
    send_request(KIND_ARRIVAL, 8'h22, 16'd4);
    send_request(KIND_ARRIVAL, 8'h33, 16'd4);
    drain_ticks();
  endtask

  task automatic test_arrival_overflow();
    gaps_on = 1'b0;
    for (int i = 0; i <= DEPTH; i++) send_request(KIND_ARRIVAL, 8'(8'h80 + i), 16'd1);
    drain_ticks();
  endtask

  // fill level lvl completely, then try to demote one more process into it
  task automatic test_demote_into_full(input int lvl);
    set_quanta(8'd1, 8'd1, 8'd1);
    for (int i = 0; i < DEPTH; i++)
      send_request(KIND_ARRIVAL, 8'(lvl * 32 + i), 16'(lvl + 1));
    repeat (DEPTH * lvl) send_tick();
    send_request(KIND_ARRIVAL, 8'hEE, 16'(lvl + 3));
    drain_ticks();
  endtask

  task automatic test_random_phases();
    logic [QUANT_W-1:0] qv [QUANT_COUNT];
    logic [BURST_W-1:0] bt;
    int flood_left;
    int roll;
    flood_left = 0;
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < QUANT_COUNT; i++) begin
        roll = $urandom_range(0, 7);
        if (phase == 0) qv[i] = 8'd1;
        else if (phase == 1) qv[i] = QUANT_MAX;
        else if (roll == 0) qv[i] = 8'd1;
        else if (roll == 1) qv[i] = QUANT_MAX;
        else if (roll == 2) qv[i] = 8'd0;
        else if (roll < 6) qv[i] = 8'($urandom_range(1, 4));
        else qv[i] = 8'($urandom_range(1, 255));
      end
      set_quanta(qv[0], qv[1], qv[2]);
      for (int n = 0; n < 80; n++) begin
        if (n % 20 == 0) gaps_on = $urandom_range(0, 1);
        roll = $urandom_range(0, 99);
        if (flood_left == 0 && roll < 6) flood_left = $urandom_range(4, 18);
        if (flood_left > 0 || roll < 40) begin
          if (flood_left > 0) flood_left--;
          roll = $urandom_range(0, 99);
          if (roll < 6) bt = '0;
          else if (roll < 90) bt = 16'($urandom_range(1, 12));
          else bt = 16'($urandom_range(13, 64));
          send_request(KIND_ARRIVAL, 8'($urandom_range(0, 255)), bt);
        end else begin
          send_tick();
        end
      end
    end
  endtask

  // full-width burst values; these may be left unfinished at the end
  task automatic test_wide_bursts();
    set_quanta(QUANT_MAX, QUANT_MAX, QUANT_MAX);
    gaps_on = 1'b1;
    send_request(KIND_ARRIVAL, 8'hC3, 16'hFFFF);
    send_request(KIND_ARRIVAL, 8'h3C, 16'h8000);
    send_request(KIND_ARRIVAL, 8'h96, 16'h5555);
    repeat (12) send_tick();
  endtask

  initial begin
    int waited;
    for (int l = 0; l < LEVELS; l++) begin
      lvl_head[l]  = '0;
      lvl_count[l] = '0;
    end
    cpu_busy    = 1'b0;
    cpu_id      = '0;
    cpu_time    = '0;
    cpu_level   = '0;
    slice_count = '0;
    quantum     = QUANT_RESET;
    gaps_on     = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_flow();
    test_quantum_zero();
    test_last_level_order();
    test_arrival_overflow();
    for (int l = 1; l < LEVELS; l++) test_demote_into_full(l);
    test_random_phases();
    test_wide_bursts();

    start_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);

    if (pending_results.size() != 0)
      $display("%0d expected results never arrived", pending_results.size());
    $display("covered %0d requests (%0d arrivals, %0d ticks), %0d quantum writes",
             arrivals_sent + ticks_sent, arrivals_sent, ticks_sent, quantum_writes);
    $display("results: ran on %0d, finished %0d, demoted %0d, idle %0d, queued %0d, dropped %0d",
             event_hits[EV_RAN_ON], event_hits[EV_FINISHED], event_hits[EV_DEMOTED],
             event_hits[EV_IDLE], event_hits[EV_QUEUED], event_hits[EV_DROPPED]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_multilevel_feedback_scheduler passed");
    end else begin
      $display("tb_multilevel_feedback_scheduler failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/mlfs_pkg.sv
design/mlfs_datapath.sv
design/mlfs_ctrl.sv
design/multilevel_feedback_scheduler.sv
bench/tb_multilevel_feedback_scheduler.sv
